@@ sv/stl_pkg.sv @@
// Shared types and constants for the source token lexer.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

  // Default widths of the position and line/column counters.
  localparam int unsigned STL_POS_BITS  = 24;
  localparam int unsigned STL_LINE_BITS = 16;

  localparam int unsigned STL_KIND_W  = 5;
  // At most three tokens follow from one byte.
  localparam int unsigned STL_MAX_TOK = 3;
  localparam int unsigned STL_IDX_W   = 2;

  // Byte codes with a role of their own.
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [STL_KIND_W-1:0] {
    KIND_EOF       = 5'd0,
    KIND_IDENT     = 5'd1,
    KIND_INTNUM    = 5'd2,
    KIND_FRACNUM   = 5'd3,
    KIND_KW_INT    = 5'd4,
    KIND_KW_FLOAT  = 5'd5,
    KIND_KW_ELSE   = 5'd6,
    KIND_KW_WHILE  = 5'd7,
    KIND_KW_FOR    = 5'd8,
    KIND_KW_RETURN = 5'd9,
    KIND_SLASH     = 5'd10,
    KIND_LPAR      = 5'd11,
    KIND_RPAR      = 5'd12,
    KIND_SEMI      = 5'd13,
    KIND_ASSIGN    = 5'd14,
    KIND_EQ        = 5'd15,
    KIND_PLUS      = 5'd16,
    KIND_INC       = 5'd17,
    KIND_MINUS     = 5'd18,
    KIND_DEC       = 5'd19,
    KIND_STAR      = 5'd20,
    KIND_POW       = 5'd21,
    KIND_UNKNOWN   = 5'd22
  } stl_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_INT   = 3'd2,
    MODE_FRAC  = 3'd3,
    MODE_OP    = 3'd4
  } stl_mode_e;

  // Held operator, in the order of its single-byte kind codes.
  typedef enum logic [1:0] {
    OP_ASSIGN = 2'd0,
    OP_PLUS   = 2'd1,
    OP_MINUS  = 2'd2,
    OP_STAR   = 2'd3
  } stl_op_e;

  // Hand-over of one byte's tokens from the scanner to the output stage.
  typedef struct packed {
    logic                 load;
    logic [STL_IDX_W-1:0] count;
  } stl_load_t;

endpackage

`default_nettype wire

@@ sv/stl_if.sv @@
// Valid/ready channel interfaces for source bytes and tokens.
`timescale 1ns / 1ps
`default_nettype none

interface stl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       last_byte;

  modport source (output valid, output byte_req, output last_byte, input ready);
  modport sink   (input valid, input byte_req, input last_byte, output ready);
endinterface

interface stl_tok_if import stl_pkg::*; #(
  parameter int unsigned POS_BITS  = STL_POS_BITS,
  parameter int unsigned LINE_BITS = STL_LINE_BITS
);
  logic                  valid;
  logic                  ready;
  logic [STL_KIND_W-1:0] kind;
  logic [POS_BITS-1:0]   first_pos;
  logic [POS_BITS-1:0]   end_pos;
  logic [LINE_BITS-1:0]  line_no;
  logic [LINE_BITS-1:0]  column_no;
  logic                  run_end;

  modport source (output valid, output kind, output first_pos, output end_pos,
                  output line_no, output column_no, output run_end, input ready);
  modport sink   (input valid, input kind, input first_pos, input end_pos,
                  input line_no, input column_no, input run_end, output ready);
endinterface

`default_nettype wire

@@ sv/stl_core.sv @@
// Byte input register, scanner state and per-byte token bundle logic.
`timescale 1ns / 1ps
`default_nettype none

module stl_core import stl_pkg::*; #(
  parameter int unsigned POS_BITS  = STL_POS_BITS,
  parameter int unsigned LINE_BITS = STL_LINE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  stl_byte_if.sink              byte_i,
  input  logic                  bundle_free_i,
  output stl_load_t             load_o,
  output logic [STL_KIND_W-1:0] kind_o  [STL_MAX_TOK],
  output logic [POS_BITS-1:0]   start_o [STL_MAX_TOK],
  output logic [POS_BITS-1:0]   end_o   [STL_MAX_TOK],
  output logic [LINE_BITS-1:0]  line_o  [STL_MAX_TOK],
  output logic [LINE_BITS-1:0]  col_o   [STL_MAX_TOK]
);

  typedef struct packed {
    logic [STL_KIND_W-1:0] kind;
    logic [POS_BITS-1:0]   spos;
    logic [POS_BITS-1:0]   epos;
    logic [LINE_BITS-1:0]  line;
    logic [LINE_BITS-1:0]  col;
  } tok_ent_t;

  function automatic logic [47:0] kw_word(input logic [2:0] k);
    logic [47:0] w;
    unique case (k)
      3'd0:    w = {24'h0, "tni"};
      3'd1:    w = {8'h0, "taolf"};
      3'd2:    w = {16'h0, "esle"};
      3'd3:    w = {8'h0, "elihw"};
      3'd4:    w = {24'h0, "rof"};
      3'd5:    w = "nruter";
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] n;
    unique case (k) inside
      3'd0, 3'd4:  n = 3'd3;
      3'd1, 3'd3:  n = 3'd5;
      3'd2:        n = 3'd4;
      3'd5:        n = 3'd6;
      default:     n = 3'd7;
    endcase
    return n;
  endfunction

  // Drop every keyword whose next character differs from c.
  function automatic logic [5:0] kw_match(input logic [5:0] cand, input logic [2:0] len,
                                          input logic [7:0] c);
    logic [5:0]  keep;
    logic [47:0] sh;
    for (int i = 0; i < 6; i++) begin
      sh      = kw_word(3'(i)) >> {len, 3'b000};
      keep[i] = cand[i] && (len < kw_len(3'(i))) && (sh[7:0] == c);
    end
    return keep;
  endfunction

  function automatic stl_kind_e op_kind(input stl_op_e op);
    return stl_kind_e'(5'(KIND_ASSIGN) + {2'b00, op, 1'b0});
  endfunction

  function automatic stl_kind_e flush_kind(input stl_mode_e m, input logic [5:0] cand,
                                           input logic [2:0] len, input stl_op_e op);
    stl_kind_e k;
    unique case (m)
      MODE_IDENT: begin
        k = KIND_IDENT;
        for (int i = 0; i < 6; i++) begin
          if (cand[i] && (len == kw_len(3'(i)))) begin
            k = stl_kind_e'(5'(KIND_KW_INT) + 5'(i));
          end
        end
      end
      MODE_INT:  k = KIND_INTNUM;
      MODE_FRAC: k = KIND_FRACNUM;
      MODE_OP:   k = op_kind(op);
      default:   k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // Input register
  logic       inq_v_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       step;

  // Scanner state
  stl_mode_e            mode_q, mode_d;
  stl_op_e              held_q, held_d;
  logic [5:0]           cand_q, cand_d;
  logic [2:0]           len_q, len_d;
  logic [POS_BITS-1:0]  tok_pos_q, tok_pos_d, cur_pos_q, cur_pos_d;
  logic [LINE_BITS-1:0] tok_line_q, tok_line_d, tok_col_q, tok_col_d;
  logic [LINE_BITS-1:0] cur_line_q, cur_line_d, cur_col_q, cur_col_d;

  // Decode
  logic      is_dig, is_alp, is_sp, is_op, consumed, starting, single;
  stl_op_e   op_b;
  stl_mode_e new_mode;
  stl_kind_e single_kind;

  // Post-byte values before an end of source is applied
  stl_mode_e            mode_nx;
  stl_op_e              held_nx;
  logic [5:0]           cand_nx, base_cand;
  logic [2:0]           len_nx, base_len;
  logic                 begin_tok, add_ch;
  logic [POS_BITS-1:0]  next_pos, tok_pos_nx;
  logic [LINE_BITS-1:0] tok_line_nx, tok_col_nx, line_nx, col_nx;

  // Results
  tok_ent_t r0, rm, re;
  logic     p0, pm;
  tok_ent_t slot [STL_MAX_TOK];

  assign byte_i.ready = !inq_v_q || bundle_free_i;
  assign step         = inq_v_q && bundle_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_v_q <= 1'b0;
    end else if (byte_i.ready) begin
      inq_v_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      byte_q <= byte_i.byte_req;
      last_q <= byte_i.last_byte;
    end
  end

  always_comb begin
    is_dig = (byte_q >= "0") && (byte_q <= "9");
    is_alp = ((byte_q >= "a") && (byte_q <= "z")) || ((byte_q >= "A") && (byte_q <= "Z"));
    is_sp  = (byte_q == CH_SPACE) || ((byte_q >= CH_TAB) && (byte_q <= CH_CR));
    is_op  = (byte_q == CH_EQ) || (byte_q == CH_PLUS) || (byte_q == CH_MINUS) ||
             (byte_q == CH_STAR);
    unique case (byte_q)
      CH_PLUS:  op_b = OP_PLUS;
      CH_MINUS: op_b = OP_MINUS;
      CH_STAR:  op_b = OP_STAR;
      default:  op_b = OP_ASSIGN;
    endcase
    unique case (byte_q)
      CH_SLASH: single_kind = KIND_SLASH;
      CH_LPAR:  single_kind = KIND_LPAR;
      CH_RPAR:  single_kind = KIND_RPAR;
      CH_SEMI:  single_kind = KIND_SEMI;
      default:  single_kind = KIND_UNKNOWN;
    endcase
    unique case (mode_q)
      MODE_IDENT: consumed = is_alp || is_dig || (byte_q == CH_UNDER);
      MODE_INT:   consumed = is_dig || (byte_q == CH_DOT);
      MODE_FRAC:  consumed = is_dig;
      MODE_OP:    consumed = is_op && (op_b == held_q);
      default:    consumed = 1'b0;
    endcase
    if (is_dig) begin
      new_mode = MODE_INT;
    end else if (is_alp || (byte_q == CH_UNDER)) begin
      new_mode = MODE_IDENT;
    end else if (is_op) begin
      new_mode = MODE_OP;
    end else begin
      new_mode = MODE_IDLE;
    end
    starting = !consumed && !is_sp;
    single   = starting && (new_mode == MODE_IDLE);
  end

  // Next state
  always_comb begin
    next_pos  = (&cur_pos_q) ? cur_pos_q : cur_pos_q + 1'b1;
    begin_tok = starting && (new_mode != MODE_IDLE);
    if (consumed) begin
      if (mode_q == MODE_OP) begin
        mode_nx = MODE_IDLE;
      end else if ((mode_q == MODE_INT) && (byte_q == CH_DOT)) begin
        mode_nx = MODE_FRAC;
      end else begin
        mode_nx = mode_q;
      end
    end else begin
      mode_nx = begin_tok ? new_mode : MODE_IDLE;
    end
    base_cand = begin_tok ? 6'h3F : cand_q;
    base_len  = begin_tok ? 3'd0 : len_q;
    add_ch    = (consumed && (mode_q != MODE_OP)) || (begin_tok && (new_mode != MODE_OP));
    if (add_ch) begin
      cand_nx = kw_match(base_cand, base_len, byte_q);
      len_nx  = (&base_len) ? base_len : base_len + 3'd1;
    end else begin
      cand_nx = base_cand;
      len_nx  = (begin_tok && (new_mode == MODE_OP)) ? 3'd1 : base_len;
    end
    held_nx     = (begin_tok && (new_mode == MODE_OP)) ? op_b : held_q;
    tok_pos_nx  = begin_tok ? cur_pos_q  : tok_pos_q;
    tok_line_nx = begin_tok ? cur_line_q : tok_line_q;
    tok_col_nx  = begin_tok ? cur_col_q  : tok_col_q;
    if (byte_q == CH_NL) begin
      line_nx = (&cur_line_q) ? cur_line_q : cur_line_q + 1'b1;
      col_nx  = LINE_BITS'(1);
    end else begin
      line_nx = cur_line_q;
      col_nx  = (&cur_col_q) ? cur_col_q : cur_col_q + 1'b1;
    end

    if (last_q) begin
      mode_d     = MODE_IDLE;
      held_d     = OP_ASSIGN;
      cand_d     = 6'h3F;
      len_d      = 3'd0;
      tok_pos_d  = '0;
      tok_line_d = LINE_BITS'(1);
      tok_col_d  = LINE_BITS'(1);
      cur_pos_d  = '0;
      cur_line_d = LINE_BITS'(1);
      cur_col_d  = LINE_BITS'(1);
    end else begin
      mode_d     = mode_nx;
      held_d     = held_nx;
      cand_d     = cand_nx;
      len_d      = len_nx;
      tok_pos_d  = tok_pos_nx;
      tok_line_d = tok_line_nx;
      tok_col_d  = tok_col_nx;
      cur_pos_d  = next_pos;
      cur_line_d = line_nx;
      cur_col_d  = col_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      held_q     <= OP_ASSIGN;
      cand_q     <= 6'h3F;
      len_q      <= 3'd0;
      tok_pos_q  <= '0;
      tok_line_q <= LINE_BITS'(1);
      tok_col_q  <= LINE_BITS'(1);
      cur_pos_q  <= '0;
      cur_line_q <= LINE_BITS'(1);
      cur_col_q  <= LINE_BITS'(1);
    end else if (step) begin
      mode_q     <= mode_d;
      held_q     <= held_d;
      cand_q     <= cand_d;
      len_q      <= len_d;
      tok_pos_q  <= tok_pos_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      cur_pos_q  <= cur_pos_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
    end
  end

  // Outputs: pending token or pair, then single byte or closing token, then EOF
  always_comb begin
    p0 = !consumed && (mode_q != MODE_IDLE) || (consumed && (mode_q == MODE_OP));
    r0.kind = (consumed && (mode_q == MODE_OP)) ?
              5'(op_kind(held_q)) + 5'd1 : 5'(flush_kind(mode_q, cand_q, len_q, held_q));
    r0.spos = tok_pos_q;
    r0.epos = consumed ? next_pos : cur_pos_q;
    r0.line = tok_line_q;
    r0.col  = tok_col_q;

    pm = single || (last_q && (mode_nx != MODE_IDLE));
    if (single) begin
      rm.kind = single_kind;
      rm.spos = cur_pos_q;
      rm.line = cur_line_q;
      rm.col  = cur_col_q;
    end else begin
      rm.kind = flush_kind(mode_nx, cand_nx, len_nx, held_nx);
      rm.spos = tok_pos_nx;
      rm.line = tok_line_nx;
      rm.col  = tok_col_nx;
    end
    rm.epos = next_pos;

    re.kind = KIND_EOF;
    re.spos = next_pos;
    re.epos = next_pos;
    re.line = line_nx;
    re.col  = col_nx;

    slot[0] = p0 ? r0 : (pm ? rm : re);
    slot[1] = (p0 && pm) ? rm : re;
    slot[2] = re;

    load_o.count = STL_IDX_W'(p0) + STL_IDX_W'(pm) + STL_IDX_W'(last_q);
    load_o.load  = step && (load_o.count != '0);
  end

  for (genvar g = 0; g < STL_MAX_TOK; g++) begin : g_slot
    assign kind_o[g]  = slot[g].kind;
    assign start_o[g] = slot[g].spos;
    assign end_o[g]   = slot[g].epos;
    assign line_o[g]  = slot[g].line;
    assign col_o[g]   = slot[g].col;
  end

  a_eof_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && last_q) |=> (mode_q == MODE_IDLE) && (cur_pos_q == '0) &&
                         (cur_line_q == LINE_BITS'(1)))
    else $error("end of source did not restart the scanner");

  a_tok_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_IDLE) |-> (tok_line_q <= cur_line_q))
    else $error("open token starts on a later line than the cursor");

  a_hold_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inq_v_q && !byte_i.ready) |=> inq_v_q && $stable(byte_q) && $stable(last_q))
    else $error("held byte lost while the output stage was busy");

endmodule

`default_nettype wire

@@ sv/stl_drain.sv @@
// Token bundle register that hands out one token per request.
`timescale 1ns / 1ps
`default_nettype none

module stl_drain import stl_pkg::*; #(
  parameter int unsigned POS_BITS  = STL_POS_BITS,
  parameter int unsigned LINE_BITS = STL_LINE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stl_load_t             load_i,
  input  logic [STL_KIND_W-1:0] kind_i  [STL_MAX_TOK],
  input  logic [POS_BITS-1:0]   start_i [STL_MAX_TOK],
  input  logic [POS_BITS-1:0]   end_i   [STL_MAX_TOK],
  input  logic [LINE_BITS-1:0]  line_i  [STL_MAX_TOK],
  input  logic [LINE_BITS-1:0]  col_i   [STL_MAX_TOK],
  output logic                  bundle_free_o,
  stl_tok_if.source             tok_o
);

  logic                  v_q;
  logic [STL_IDX_W-1:0]  idx_q, cnt_q;
  logic [STL_KIND_W-1:0] kind_q  [STL_MAX_TOK];
  logic [POS_BITS-1:0]   start_q [STL_MAX_TOK];
  logic [POS_BITS-1:0]   end_q   [STL_MAX_TOK];
  logic [LINE_BITS-1:0]  line_q  [STL_MAX_TOK];
  logic [LINE_BITS-1:0]  col_q   [STL_MAX_TOK];
  logic                  fire, at_last;

  assign fire          = v_q && tok_o.ready;
  assign at_last       = (idx_q == cnt_q - 1'b1);
  assign bundle_free_o = !v_q || (fire && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      idx_q <= '0;
      cnt_q <= '0;
    end else if (load_i.load) begin
      v_q   <= 1'b1;
      idx_q <= '0;
      cnt_q <= load_i.count;
    end else if (fire) begin
      if (at_last) begin
        v_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      kind_q  <= kind_i;
      start_q <= start_i;
      end_q   <= end_i;
      line_q  <= line_i;
      col_q   <= col_i;
    end
  end

  assign tok_o.valid     = v_q;
  assign tok_o.kind      = kind_q[idx_q];
  assign tok_o.first_pos = start_q[idx_q];
  assign tok_o.end_pos   = end_q[idx_q];
  assign tok_o.line_no   = line_q[idx_q];
  assign tok_o.column_no = col_q[idx_q];
  assign tok_o.run_end   = at_last;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> (idx_q < cnt_q))
    else $error("token index ran past the bundle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.load |-> bundle_free_o)
    else $error("bundle loaded over tokens not yet taken");

  a_hold_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q && !tok_o.ready) |=> v_q && $stable(idx_q))
    else $error("offered token moved before its request was taken");

endmodule

`default_nettype wire

@@ sv/source_token_lexer.sv @@
// Top level of the streaming source token lexer.
// Flow: an accepted byte waits in the input register until it is scanned,
//   which writes its tokens to the bundle register that drives tok_o.
// Throughput: one byte per cycle while each byte yields at most one token and
//   tok_o is ready; more tokens per byte hold the input until all are taken.
// Reset: asynchronous, active low; position 0, line 1, column 1, no open token.
`timescale 1ns / 1ps
`default_nettype none

module source_token_lexer import stl_pkg::*; #(
  parameter int unsigned POS_BITS  = STL_POS_BITS,
  parameter int unsigned LINE_BITS = STL_LINE_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stl_byte_if.sink  byte_i,
  stl_tok_if.source tok_o
);

  // The datapath has two register stages:
  //   1. stl_core holds the accepted byte in an input register and, in one
  //      pass of short logic against the scanner state, works out every
  //      token that byte causes: the token it closes (or the doubled
  //      operator it completes), a single-byte token or, at end of source,
  //      the token left open, and the EOF token. The scanner state advances
  //      in the same cycle the bundle is written.
  //   2. stl_drain keeps that bundle and hands it out one token per request,
  //      marking the last one with run_end.
  // A byte advances out of the input register only when the bundle register
  // is empty or gives up its last token in the same cycle; a new byte is taken
  // while a finished token waits only if the input register is empty.

  stl_load_t             load;
  logic                  bundle_free;
  logic [STL_KIND_W-1:0] kind  [STL_MAX_TOK];
  logic [POS_BITS-1:0]   spos  [STL_MAX_TOK];
  logic [POS_BITS-1:0]   epos  [STL_MAX_TOK];
  logic [LINE_BITS-1:0]  line  [STL_MAX_TOK];
  logic [LINE_BITS-1:0]  col   [STL_MAX_TOK];

  // Scanner: classify the byte, advance the counters, build the bundle.
  stl_core #(
    .POS_BITS  (POS_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_i        (byte_i),
    .bundle_free_i (bundle_free),
    .load_o        (load),
    .kind_o        (kind),
    .start_o       (spos),
    .end_o         (epos),
    .line_o        (line),
    .col_o         (col)
  );

  // Output stage: hold the bundle, advance one token per request.
  stl_drain #(
    .POS_BITS  (POS_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_drain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .kind_i        (kind),
    .start_i       (spos),
    .end_i         (epos),
    .line_i        (line),
    .col_i         (col),
    .bundle_free_o (bundle_free),
    .tok_o         (tok_o)
  );

endmodule

`default_nettype wire

@@ sim/source_token_lexer_tb.sv @@
// Self-checking testbench for the source token lexer: random C-like text against a predictor.
`timescale 1ns / 1ps
`default_nettype none

module source_token_lexer_tb;
  import stl_pkg::*;

  localparam int unsigned PB = STL_POS_BITS;
  localparam int unsigned LB = STL_LINE_BITS;
  // Stretch of cycles in which neither side idles.
  localparam int CALM_FROM = 150;
  localparam int CALM_TO   = 450;
  localparam int RAND_BYTES = 330;

  typedef struct packed {
    logic [STL_KIND_W-1:0] kind;
    logic [PB-1:0]         first_pos;
    logic [PB-1:0]         end_pos;
    logic [LB-1:0]         line_no;
    logic [LB-1:0]         column_no;
    logic                  run_end;
  } token_t;

  // One source byte request; hold_back keeps it until every due token has arrived.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       hold_back;
  } src_byte_t;

  logic clk_i;
  logic rst_ni;

  stl_byte_if byte_if ();
  stl_tok_if  tok_if ();

  source_token_lexer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .tok_o  (tok_if)
  );

  src_byte_t  src_q[$];
  logic [7:0] txt_q[$];
  token_t     tokens_due[$];

  int cyc;
  int cycle_limit;
  int err_cnt;
  int tok_seen;

  // Lexer state as the predictor sees it.
  stl_mode_e     lx_mode;
  logic [7:0]    lx_held;
  logic [5:0]    lx_cand;
  logic [PB-1:0] lx_len;
  logic [PB-1:0] lx_tstart;
  logic [LB-1:0] lx_tline;
  logic [LB-1:0] lx_tcol;
  logic [PB-1:0] lx_pos;
  logic [LB-1:0] lx_line;
  logic [LB-1:0] lx_col;
  token_t        burst [STL_MAX_TOK];
  int            burst_n;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= cycle_limit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Character classes and keyword spelling
  // ---------------------------------------------------------------------------
  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Blank covers space and the control codes from tab to carriage return.
  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Keyword order matches the kind codes from KIND_KW_INT upwards.
  function automatic string kw_name(input int k);
    case (k)
      0: return "int";
      1: return "float";
      2: return "else";
      3: return "while";
      4: return "for";
      default: return "return";
    endcase
  endfunction

  function automatic logic [STL_KIND_W-1:0] op_kind(input logic [7:0] c);
    case (c)
      CH_EQ:    return KIND_ASSIGN;
      CH_PLUS:  return KIND_PLUS;
      CH_MINUS: return KIND_MINUS;
      CH_STAR:  return KIND_STAR;
      default:  return KIND_UNKNOWN;
    endcase
  endfunction

  // Saturating counters: hold at the top instead of wrapping.
  function automatic logic [PB-1:0] pos_inc(input logic [PB-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [LB-1:0] line_inc(input logic [LB-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  task automatic lex_clear();
    lx_mode   = MODE_IDLE;
    lx_held   = '0;
    lx_cand   = '1;
    lx_len    = '0;
    lx_tstart = '0;
    lx_tline  = LB'(1);
    lx_tcol   = LB'(1);
    lx_pos    = '0;
    lx_line   = LB'(1);
    lx_col    = LB'(1);
  endtask

  task automatic lex_emit(input logic [STL_KIND_W-1:0] kind, input logic [PB-1:0] start,
                          input logic [PB-1:0] stop, input logic [LB-1:0] line,
                          input logic [LB-1:0] col);
    if (burst_n < STL_MAX_TOK) begin
      burst[burst_n].kind      = kind;
      burst[burst_n].first_pos = start;
      burst[burst_n].end_pos   = stop;
      burst[burst_n].line_no   = line;
      burst[burst_n].column_no = col;
      burst[burst_n].run_end   = 1'b0;
      burst_n++;
    end
  endtask

  task automatic lex_open(input stl_mode_e m);
    lx_mode   = m;
    lx_tstart = lx_pos;
    lx_tline  = lx_line;
    lx_tcol   = lx_col;
    lx_len    = '0;
    lx_cand   = '1;
  endtask

  // Append a byte to the open word and drop keywords it no longer spells.
  task automatic lex_take(input logic [7:0] c);
    string s;
    for (int i = 0; i < 6; i++) begin
      s = kw_name(i);
      if (lx_len >= s.len() || s[lx_len] != c) lx_cand[i] = 1'b0;
    end
    lx_len = pos_inc(lx_len);
  endtask

  // Close the open token, if any, ending it at stop.
  task automatic lex_close(input logic [PB-1:0] stop);
    logic [STL_KIND_W-1:0] kind;
    string s;
    kind = KIND_UNKNOWN;
    case (lx_mode)
      MODE_IDENT: begin
        kind = KIND_IDENT;
        for (int i = 0; i < 6; i++) begin
          s = kw_name(i);
          if (lx_cand[i] && lx_len == s.len()) kind = STL_KIND_W'(KIND_KW_INT + i);
        end
      end
      MODE_INT:  kind = KIND_INTNUM;
      MODE_FRAC: kind = KIND_FRACNUM;
      MODE_OP:   kind = op_kind(lx_held);
      default: ;
    endcase
    if (lx_mode != MODE_IDLE) lex_emit(kind, lx_tstart, stop, lx_tline, lx_tcol);
    lx_mode = MODE_IDLE;
    lx_held = '0;
  endtask

  // Advance the predictor by one accepted byte and queue the tokens it causes.
  task automatic lex_byte(input logic [7:0] b, input logic last);
    logic [PB-1:0]         nxt;
    logic [STL_KIND_W-1:0] kind;
    bit                    took;
    burst_n = 0;
    nxt     = pos_inc(lx_pos);
    took    = 1'b0;
    case (lx_mode)
      MODE_IDENT: begin
        if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
          lex_take(b);
          took = 1'b1;
        end
      end
      MODE_INT: begin
        if (is_digit(b)) begin
          lex_take(b);
          took = 1'b1;
        end else if (b == CH_DOT) begin
          lx_mode = MODE_FRAC;
          lex_take(b);
          took = 1'b1;
        end
      end
      MODE_FRAC: begin
        if (is_digit(b)) begin
          lex_take(b);
          took = 1'b1;
        end
      end
      MODE_OP: begin
        // A matching second byte completes the doubled operator at once.
        if (b == lx_held) begin
          lex_emit(op_kind(b) + 1'b1, lx_tstart, nxt, lx_tline, lx_tcol);
          lx_mode = MODE_IDLE;
          lx_held = '0;
          took    = 1'b1;
        end
      end
      default: ;
    endcase
    if (!took && lx_mode != MODE_IDLE) lex_close(lx_pos);

    if (!took && !is_blank(b)) begin
      if (is_digit(b)) begin
        lex_open(MODE_INT);
        lex_take(b);
      end else if (is_alpha(b) || b == CH_UNDER) begin
        lex_open(MODE_IDENT);
        lex_take(b);
      end else if (b == CH_EQ || b == CH_PLUS || b == CH_MINUS || b == CH_STAR) begin
        lex_open(MODE_OP);
        lx_held = b;
        lx_len  = PB'(1);
      end else begin
        case (b)
          CH_SLASH: kind = KIND_SLASH;
          CH_LPAR:  kind = KIND_LPAR;
          CH_RPAR:  kind = KIND_RPAR;
          CH_SEMI:  kind = KIND_SEMI;
          default:  kind = KIND_UNKNOWN;
        endcase
        lex_emit(kind, lx_pos, nxt, lx_line, lx_col);
      end
    end

    if (b == CH_NL) begin
      lx_line = line_inc(lx_line);
      lx_col  = LB'(1);
    end else begin
      lx_col = line_inc(lx_col);
    end
    lx_pos = nxt;

    if (last) begin
      lex_close(lx_pos);
      lex_emit(KIND_EOF, lx_pos, lx_pos, lx_line, lx_col);
      lex_clear();
    end

    for (int i = 0; i < burst_n; i++) begin
      if (i == burst_n - 1) burst[i].run_end = 1'b1;
      tokens_due.push_back(burst[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic bit take_gap();
    if (cyc >= CALM_FROM && cyc < CALM_TO) return 1'b0;
    return $urandom_range(99) < 9;
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + r[7:0];
  endfunction

  function automatic logic [7:0] digit_char();
    int r;
    r = $urandom_range(0, 9);
    return "0" + r[7:0];
  endfunction

  function automatic logic [7:0] word_char(input bit first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return "a" + r[7:0];
    if (r < 52) return "A" + r[7:0] - 8'd26;
    if (r == 52) return CH_UNDER;
    return "0" + r[7:0] - 8'd53;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) txt_q.push_back(s[i]);
  endtask

  task automatic add_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) txt_q.push_back(digit_char());
  endtask

  // Turn the collected text into requests; mark its final byte as the last one.
  task automatic seal_source(input bit hold_first);
    src_byte_t item;
    for (int i = 0; i < txt_q.size(); i++) begin
      item.code      = txt_q[i];
      item.last      = (i == txt_q.size() - 1);
      item.hold_back = hold_first && (i == 0);
      src_q.push_back(item);
    end
    txt_q.delete();
  endtask

  // Mostly well-formed tokens, with some noise bytes mixed in.
  task automatic add_random_token();
    string s;
    logic [7:0] op;
    case ($urandom_range(0, 11))
      0: add_text(kw_name($urandom_range(0, 5)));
      1: begin
        // Near-keyword: one byte short or one byte long.
        s = kw_name($urandom_range(0, 5));
        if ($urandom_range(0, 1)) add_text(s.substr(0, s.len() - 2));
        else begin
          add_text(s);
          txt_q.push_back(word_char(1'b0));
        end
      end
      2: begin
        txt_q.push_back(word_char(1'b1));
        repeat ($urandom_range(0, 7)) txt_q.push_back(word_char(1'b0));
      end
      3: add_digits(1, 6);
      4: begin
        add_digits(1, 4);
        txt_q.push_back(CH_DOT);
        add_digits(0, 3);
      end
      5: begin
        // Number with a second dot.
        add_digits(1, 3);
        txt_q.push_back(CH_DOT);
        add_digits(0, 2);
        txt_q.push_back(CH_DOT);
      end
      6: begin
        case ($urandom_range(0, 3))
          0: op = CH_EQ;
          1: op = CH_PLUS;
          2: op = CH_MINUS;
          default: op = CH_STAR;
        endcase
        repeat ($urandom_range(1, 3)) txt_q.push_back(op);
      end
      7: begin
        case ($urandom_range(0, 3))
          0: txt_q.push_back(CH_SLASH);
          1: txt_q.push_back(CH_LPAR);
          2: txt_q.push_back(CH_RPAR);
          default: txt_q.push_back(CH_SEMI);
        endcase
      end
      8: txt_q.push_back(8'($urandom_range(0, 255)));
      9: begin
        if ($urandom_range(0, 1)) txt_q.push_back(CH_DOT);
        else txt_q.push_back(8'($urandom_range(128, 255)));
      end
      default: txt_q.push_back(blank_char());
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver: present the next request once the slot frees up
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.valid     <= 1'b0;
      byte_if.byte_req  <= '0;
      byte_if.last_byte <= 1'b0;
      lex_clear();
    end else begin
      if (byte_if.valid && byte_if.ready) lex_byte(byte_if.byte_req, byte_if.last_byte);
      if (!byte_if.valid || byte_if.ready) begin
        // Hold a marked request back until the token stream has drained.
        if (src_q.size() != 0 && !take_gap() &&
            !(src_q[0].hold_back && tokens_due.size() != 0)) begin
          byte_if.valid     <= 1'b1;
          byte_if.byte_req  <= src_q[0].code;
          byte_if.last_byte <= src_q[0].last;
          void'(src_q.pop_front());
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Token monitor: compare every accepted token with the oldest one due
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (err_cnt < 100) $display("MISMATCH @%0d: %s", cyc, msg);
    err_cnt++;
  endtask

  task automatic check_token();
    token_t want;
    if (tokens_due.size() == 0) begin
      report_mismatch($sformatf("token %0d (kind %0d) with none due", tok_seen, tok_if.kind));
    end else begin
      want = tokens_due.pop_front();
      if (tok_if.kind !== want.kind)
        report_mismatch($sformatf("token %0d kind %0d, want %0d",
                                  tok_seen, tok_if.kind, want.kind));
      if (tok_if.first_pos !== want.first_pos)
        report_mismatch($sformatf("token %0d start %0d, want %0d",
                                  tok_seen, tok_if.first_pos, want.first_pos));
      if (tok_if.end_pos !== want.end_pos)
        report_mismatch($sformatf("token %0d end %0d, want %0d",
                                  tok_seen, tok_if.end_pos, want.end_pos));
      if (tok_if.line_no !== want.line_no)
        report_mismatch($sformatf("token %0d line %0d, want %0d",
                                  tok_seen, tok_if.line_no, want.line_no));
      if (tok_if.column_no !== want.column_no)
        report_mismatch($sformatf("token %0d column %0d, want %0d",
                                  tok_seen, tok_if.column_no, want.column_no));
      if (tok_if.run_end !== want.run_end)
        report_mismatch($sformatf("token %0d run_end %0b, want %0b",
                                  tok_seen, tok_if.run_end, want.run_end));
    end
    tok_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_if.ready <= 1'b0;
    end else begin
      tok_if.ready <= !take_gap();
      if (tok_if.valid && tok_if.ready) check_token();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int n_rand;
    int n_src;
    rst_ni      = 1'b0;
    cycle_limit = 1000000;

    // Directed source: keyword, word with underscore and a digit, second dot,
    // a tripled operator, doubled operators, punctuation, NUL and a high byte.
    add_text("for x_Z9\t1.5.===**--;/()\n");
    txt_q.push_back(8'h00);
    txt_q.push_back(8'hFF);
    seal_source(1'b0);

    // Random sources, each closed by a last byte; every fourth waits for a drain.
    n_rand = 0;
    n_src  = 0;
    while (n_rand < RAND_BYTES) begin
      repeat ($urandom_range(1, 10)) begin
        add_random_token();
        if ($urandom_range(0, 1)) txt_q.push_back(blank_char());
      end
      n_rand += txt_q.size();
      seal_source(n_src % 4 == 3);
      n_src++;
    end

    // Up to three tokens per byte plus random stalls on both sides.
    cycle_limit = 20 * src_q.size() + 20000;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (src_q.size() != 0 || byte_if.valid || tokens_due.size() != 0) @(posedge clk_i);
    // Allow for the pipeline latency so any stray token is caught.
    repeat (8) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
